// ===== sv/rmm2d_pkg.sv =====
// Package for the range_min_max_2d_tree block: widths, sentinels and the
// sequencer state type. Depends on nothing.
`default_nettype none
package rmm2d_pkg;
   localparam int Grid = 64;
   localparam int IdxW = 6;                      // log2(Grid)
   localparam int AddrW = 2 * IdxW;
   localparam int CoordW = 7;
   localparam int ValW = 32;
   localparam logic signed [ValW-1:0] HighSentinel = 32'sh3f3f3f3f;
   localparam logic signed [ValW-1:0] LowSentinel = -32'sh3f3f3f3f;
   localparam logic [CoordW-1:0] GridReset = CoordW'(Grid);
   localparam logic CmdWrite = 1'b0;
   localparam logic CmdQuery = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;
endpackage
`default_nettype wire

// ===== sv/range_min_max_2d_tree.sv =====
// Top level of the range_min_max_2d_tree block: handshake, sequencer and the
// shared compare unit. Uses rmm2d_pkg and rmm2d_store.
//
// channel  direction  handshake                ports
// req      in         start & !busy            req_cmd, req_row_*, req_col_*, req_cell_value
// rsp      out        rsp_strobe, one cycle    rsp_min_value, rsp_max_value, rsp_bad_range
// csr      in         csr_valid & csr_ready    csr_data (grid_size)
//
// From acceptance, an update or a bad word passes through ST_DONE and then the registered rsp_strobe.
// A query reads one cell a cycle through the single memory read port, row
// by row, then passes ST_DRAIN and ST_DONE before its response.
// After reset and after each grid_size write a clearing pass writes the
// memory once per cell while busy stays high; csr writes are still taken
// then. The receiver cannot stall, so a response never waits.
`default_nettype none
module range_min_max_2d_tree (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire                           req_cmd,
   input  wire [rmm2d_pkg::CoordW-1:0]   req_row_low,
   input  wire [rmm2d_pkg::CoordW-1:0]   req_row_high,
   input  wire [rmm2d_pkg::CoordW-1:0]   req_col_low,
   input  wire [rmm2d_pkg::CoordW-1:0]   req_col_high,
   input  wire signed [rmm2d_pkg::ValW-1:0] req_cell_value,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [rmm2d_pkg::CoordW-1:0]   csr_data,
   output logic                          rsp_strobe,
   output logic signed [rmm2d_pkg::ValW-1:0] rsp_min_value,
   output logic signed [rmm2d_pkg::ValW-1:0] rsp_max_value,
   output logic                          rsp_bad_range
);
   import rmm2d_pkg::*;

   state_type state_ff, state_in;
   logic [CoordW-1:0] grid_ff, grid_in, clamp;
   logic epoch_ff, epoch_in;
   logic [AddrW-1:0] clr_ff, clr_in;
   logic [IdxW-1:0] r_ff, r_in, c_ff, c_in, r2_ff, c1_ff, c2_ff;
   logic [IdxW-1:0] r2_in, c1_in, c2_in;
   logic last_ff, last_in;
   logic rdv_ff, rdv_in;
   logic signed [ValW-1:0] mn_ff, mn_in, mx_ff, mx_in;
   logic bad_ff, bad_in, strobe_ff, strobe_in;
   logic wr_en;
   logic wr_tag;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [ValW-1:0] wr_data, rd_data;
   logic rd_epoch;
   logic signed [ValW-1:0] cell_min, cell_max;
   logic bad_q, bad_u;

   // Clamp the written size: zero becomes one, above the grid saturates.
   always_comb begin
      clamp = csr_data;
      if (csr_data == '0) clamp = CoordW'(1);
      else if (csr_data > GridReset) clamp = GridReset;
   end

   assign bad_u = req_row_low == '0 || req_row_low > grid_ff ||
                  req_col_low == '0 || req_col_low > grid_ff;
   assign bad_q = req_row_low == '0 || req_col_low == '0 ||
                  req_row_low > req_row_high || req_col_low > req_col_high ||
                  req_row_high > grid_ff || req_col_high > grid_ff;

   assign busy = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   // The clearing pass tags every cell with the other epoch, so that each
   // cell reads as unwritten until an update stores it.
   assign wr_tag = (state_ff == ST_CLEAR) ? !epoch_ff : epoch_ff;

   rmm2d_store u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .wr_epoch(wr_tag), .rd_addr(rd_addr), .rd_data(rd_data),
      .rd_epoch(rd_epoch)
   );

   // A cell from an older epoch counts as unwritten.
   assign cell_min = (rd_epoch == epoch_ff) ? signed'(rd_data) : HighSentinel;
   assign cell_max = (rd_epoch == epoch_ff) ? signed'(rd_data) : LowSentinel;
   assign rd_addr = {r_ff, c_ff};

   always_comb begin
      state_in = state_ff;
      grid_in = grid_ff;
      epoch_in = epoch_ff;
      clr_in = clr_ff;
      r_in = r_ff; c_in = c_ff; r2_in = r2_ff; c1_in = c1_ff; c2_in = c2_ff;
      last_in = 1'b0;
      rdv_in = 1'b0;
      mn_in = mn_ff; mx_in = mx_ff;
      bad_in = bad_ff;
      strobe_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = {IdxW'(req_row_low - 1'b1), IdxW'(req_col_low - 1'b1)};
      wr_data = req_cell_value;
      // Shared compare unit folds the cell read last cycle.
      if (rdv_ff) begin
         if (cell_min < mn_ff) mn_in = cell_min;
         if (cell_max > mx_ff) mx_in = cell_max;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mn_in = '0; mx_in = '0;
               if (req_cmd == CmdWrite) begin
                  bad_in = bad_u;
                  wr_en = !bad_u;
                  state_in = ST_DONE;
               end else if (bad_q) begin
                  bad_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  bad_in = 1'b0;
                  mn_in = 32'sh7fffffff;
                  mx_in = 32'sh80000000;
                  r_in = IdxW'(req_row_low - 1'b1);
                  c_in = IdxW'(req_col_low - 1'b1);
                  r2_in = IdxW'(req_row_high - 1'b1);
                  c1_in = IdxW'(req_col_low - 1'b1);
                  c2_in = IdxW'(req_col_high - 1'b1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            // Old-epoch tags already read as sentinels; this pass just keeps
            // a stale tag from aliasing after the epoch bit wraps.
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = HighSentinel;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            rdv_in = 1'b1;
            if (c_ff == c2_ff) begin
               c_in = c1_ff;
               r_in = r_ff + 1'b1;
               if (r_ff == r2_ff) state_in = ST_DRAIN;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            last_in = 1'b1;
            if (last_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_valid) begin
         grid_in = clamp;
         epoch_in = !epoch_ff;
         clr_in = '0;
         state_in = ST_CLEAR;
      end
   end

   // A grid_size write during a clearing pass flips the epoch and restarts
   // the pass, so every cell still ends up tagged as unwritten.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         grid_ff <= GridReset;
         epoch_ff <= 1'b0;
         clr_ff <= '0;
         rdv_ff <= 1'b0;
         last_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         grid_ff <= grid_in;
         epoch_ff <= epoch_in;
         clr_ff <= clr_in;
         rdv_ff <= rdv_in;
         last_ff <= last_in;
         strobe_ff <= strobe_in;
      end
      r_ff <= r_in; c_ff <= c_in; r2_ff <= r2_in; c1_ff <= c1_in; c2_ff <= c2_in;
      mn_ff <= mn_in; mx_ff <= mx_in; bad_ff <= bad_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_min_value = mn_ff;
   assign rsp_max_value = mx_ff;
   assign rsp_bad_range = bad_ff;
endmodule
`default_nettype wire

// ===== sv/rmm2d_store.sv =====
// Cell store of the range_min_max_2d_tree block: one memory of cell values
// plus the epoch that marks a cell as written. Uses rmm2d_pkg.
`default_nettype none
module rmm2d_store (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire [rmm2d_pkg::AddrW-1:0]    wr_addr,
   input  wire [rmm2d_pkg::ValW-1:0]     wr_data,
   input  wire                           wr_epoch,
   input  wire [rmm2d_pkg::AddrW-1:0]    rd_addr,
   output logic [rmm2d_pkg::ValW-1:0]    rd_data,
   output logic                          rd_epoch
);
   import rmm2d_pkg::*;
   logic [ValW:0] mem [Grid*Grid];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_epoch, wr_data};
      end
      {rd_epoch, rd_data} <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for range_min_max_2d_tree: a directed table, then
// random words over several grid sizes and idle patterns. Uses rmm2d_pkg.
`timescale 1ns / 100ps
module tb;
   import rmm2d_pkg::*;

   typedef struct packed {
      logic signed [ValW-1:0] lo;
      logic signed [ValW-1:0] hi;
      logic                   bad;
   } answer_type;

   typedef struct {
      logic                   cmd;
      logic [CoordW-1:0]      row_lo;
      logic [CoordW-1:0]      row_hi;
      logic [CoordW-1:0]      col_lo;
      logic [CoordW-1:0]      col_hi;
      logic signed [ValW-1:0] value;
      bit                     typed;
      answer_type             answer;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   req_cmd = CmdWrite;
   logic [CoordW-1:0]      req_row_low = '0;
   logic [CoordW-1:0]      req_row_high = '0;
   logic [CoordW-1:0]      req_col_low = '0;
   logic [CoordW-1:0]      req_col_high = '0;
   logic signed [ValW-1:0] req_cell_value = '0;
   logic                   csr_valid = 1'b0;
   logic [CoordW-1:0]      csr_data = '0;
   wire                    busy;
   wire                    csr_ready;
   wire                    rsp_strobe;
   wire signed [ValW-1:0]  rsp_min_value;
   wire signed [ValW-1:0]  rsp_max_value;
   wire                    rsp_bad_range;

   // The predictor keeps one entry per cell, like the block's store; the min
   // and max of a rectangle come from a scan over its cells.
   logic signed [ValW-1:0] cell_min [Grid*Grid];
   logic signed [ValW-1:0] cell_max [Grid*Grid];
   int                     grid_now;
   answer_type             pending_answers[$];
   stim_row_type           directed_rows[$];
   int                     error_count = 0;
   int                     idle_pct = 0;

   range_min_max_2d_tree u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_row_low(req_row_low), .req_row_high(req_row_high),
      .req_col_low(req_col_low), .req_col_high(req_col_high),
      .req_cell_value(req_cell_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_min_value(rsp_min_value),
      .rsp_max_value(rsp_max_value), .rsp_bad_range(rsp_bad_range)
   );

   always #5 clock = ~clock;

   // Clearing the grid mirrors the rebuild that a grid_size write causes.
   function automatic void set_grid(int raw);
      int k;
      grid_now = raw & 8'h7f;
      if (grid_now < 1) grid_now = 1;
      if (grid_now > Grid) grid_now = Grid;
      for (k = 0; k < Grid * Grid; k++) begin
         cell_min[k] = HighSentinel;
         cell_max[k] = LowSentinel;
      end
   endfunction

   // Works out the word that the block must return for one accepted command,
   // and applies an update to the predicted grid.
   function automatic answer_type rect_min_max(stim_row_type s);
      answer_type a;
      int rl, rh, cl, ch, r, c;
      rl = s.row_lo;
      rh = s.row_hi;
      cl = s.col_lo;
      ch = s.col_hi;
      a = '{lo: '0, hi: '0, bad: 1'b0};
      if (s.cmd == CmdWrite) begin
         if (rl < 1 || rl > grid_now || cl < 1 || cl > grid_now) begin
            a.bad = 1'b1;
         end else begin
            cell_min[(rl - 1) * Grid + cl - 1] = s.value;
            cell_max[(rl - 1) * Grid + cl - 1] = s.value;
         end
      end else if (rl < 1 || cl < 1 || rl > rh || cl > ch ||
                   rh > grid_now || ch > grid_now) begin
         a.bad = 1'b1;
      end else begin
         a.lo = 32'sh7fffffff;
         a.hi = 32'sh80000000;
         for (r = rl; r <= rh; r++) begin
            for (c = cl; c <= ch; c++) begin
               if (cell_min[(r - 1) * Grid + c - 1] < a.lo) a.lo = cell_min[(r - 1) * Grid + c - 1];
               if (cell_max[(r - 1) * Grid + c - 1] > a.hi) a.hi = cell_max[(r - 1) * Grid + c - 1];
            end
         end
      end
      return a;
   endfunction

   task automatic report(string what, logic [ValW-1:0] want, logic [ValW-1:0] got);
      $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
      error_count++;
   endtask

   // Every response word is checked against the oldest outstanding answer.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_answers.size() == 0) begin
            report("unexpected word", '0, rsp_min_value);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_min_value !== want.lo) report("min_value", want.lo, rsp_min_value);
            if (rsp_max_value !== want.hi) report("max_value", want.hi, rsp_max_value);
            if (rsp_bad_range !== want.bad) begin
               report("bad_range", ValW'(want.bad), ValW'(rsp_bad_range));
            end
         end
      end
   end

   // Presents one command word and returns at the edge that accepts it. Start
   // is only lowered when a gap is taken, so it never gets two updates in one
   // step.
   task automatic send_word(stim_row_type s);
      answer_type a;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_cmd <= s.cmd;
      req_row_low <= s.row_lo;
      req_row_high <= s.row_hi;
      req_col_low <= s.col_lo;
      req_col_high <= s.col_hi;
      req_cell_value <= s.value;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      a = rect_min_max(s);
      pending_answers.push_back(s.typed ? s.answer : a);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // The grid_size register is only written with the block idle, after every outstanding response has come back.
   task automatic write_grid(int raw);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_data <= CoordW'(raw);
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      set_grid(raw);
   endtask

   task automatic add_row(logic cmd, int rl, int rh, int cl, int ch, logic [ValW-1:0] v,
                          bit typed, logic [ValW-1:0] lo, logic [ValW-1:0] hi, logic bad);
      stim_row_type s;
      s = '{cmd: cmd, row_lo: CoordW'(rl), row_hi: CoordW'(rh), col_lo: CoordW'(cl),
            col_hi: CoordW'(ch), value: v, typed: typed,
            answer: '{lo: lo, hi: hi, bad: bad}};
      directed_rows.push_back(s);
   endtask

   // Random words: mostly in-range updates and small rectangles so the grid
   // fills and queries hit written cells, a few full-grid queries, and some
   // noise with every coordinate bit free.
   function automatic stim_row_type random_word();
      stim_row_type s;
      int span;
      s.typed = 1'b0;
      s.answer = '{lo: '0, hi: '0, bad: 1'b0};
      s.value = $urandom;
      if ($urandom_range(7) == 0) s.value = $urandom_range(3) - 1;
      s.cmd = ($urandom_range(1) == 0) ? CmdWrite : CmdQuery;
      if ($urandom_range(99) < 10) begin
         s.row_lo = $urandom_range(127);
         s.row_hi = $urandom_range(127);
         s.col_lo = $urandom_range(127);
         s.col_hi = $urandom_range(127);
      end else if (s.cmd == CmdQuery && $urandom_range(99) < 2) begin
         s.row_lo = 1;
         s.col_lo = 1;
         s.row_hi = grid_now;
         s.col_hi = grid_now;
      end else begin
         s.row_lo = $urandom_range(grid_now, 1);
         s.col_lo = $urandom_range(grid_now, 1);
         span = grid_now - s.row_lo;
         s.row_hi = s.row_lo + $urandom_range(span < 7 ? span : 7);
         span = grid_now - s.col_lo;
         s.col_hi = s.col_lo + $urandom_range(span < 7 ? span : 7);
      end
      return s;
   endfunction

   initial begin
      int sizes[6] = '{1, 0, 127, 5, 64, 37};
      int idles[3] = '{0, 86, 36};
      int p, n;
      set_grid(Grid);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset grid size of 64.
      add_row(CmdQuery, 1, 64, 1, 64, 0, 1, HighSentinel, LowSentinel, 0);
      add_row(CmdWrite, 1, 0, 1, 0, 32'h80000000, 1, 0, 0, 0);
      add_row(CmdWrite, 64, 127, 64, 127, 32'h7fffffff, 1, 0, 0, 0);
      add_row(CmdQuery, 1, 64, 1, 64, 0, 1, 32'h80000000, 32'h7fffffff, 0);
      add_row(CmdQuery, 1, 1, 1, 1, 0, 1, 32'h80000000, 32'h80000000, 0);
      add_row(CmdQuery, 2, 3, 2, 3, 0, 1, HighSentinel, LowSentinel, 0);
      add_row(CmdWrite, 0, 1, 1, 1, 5, 1, 0, 0, 1);
      add_row(CmdWrite, 65, 1, 1, 1, 5, 1, 0, 0, 1);
      add_row(CmdWrite, 1, 1, 0, 1, 5, 1, 0, 0, 1);
      add_row(CmdWrite, 1, 1, 127, 1, 5, 1, 0, 0, 1);
      add_row(CmdQuery, 0, 2, 1, 2, 0, 1, 0, 0, 1);
      add_row(CmdQuery, 1, 2, 0, 2, 0, 1, 0, 0, 1);
      add_row(CmdQuery, 3, 2, 1, 2, 0, 1, 0, 0, 1);
      add_row(CmdQuery, 1, 2, 4, 3, 0, 1, 0, 0, 1);
      add_row(CmdQuery, 1, 65, 1, 2, 0, 1, 0, 0, 1);
      add_row(CmdQuery, 1, 2, 1, 127, 0, 1, 0, 0, 1);
      add_row(CmdWrite, 3, 0, 5, 0, -5, 0, 0, 0, 0);
      add_row(CmdWrite, 3, 0, 6, 0, 32'h3f3f3f40, 0, 0, 0, 0);
      add_row(CmdWrite, 4, 0, 7, 0, 32'hc0c0c0c0, 0, 0, 0, 0);
      add_row(CmdQuery, 2, 4, 4, 7, 0, 0, 0, 0, 0);
      add_row(CmdQuery, 3, 3, 6, 6, 0, 0, 0, 0, 0);
      add_row(CmdQuery, 64, 64, 1, 64, 0, 0, 0, 0, 0);
      foreach (directed_rows[i]) send_word(directed_rows[i]);

      // Random phases over grid sizes including both extremes and the two
      // values that must be clamped, taking three idle patterns in turn.
      for (p = 0; p < 6; p++) begin
         write_grid(sizes[p]);
         idle_pct = idles[p % 3];
         for (n = 0; n < 305; n++) begin
            send_word(random_word());
            if (p == 2 && n == 150) wait_drained();
         end
      end

      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
